[design/stbs_pkg.sv]
`default_nettype none

package stbs_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int VALUE_W             = 32;
   localparam int INDEX_W             = 8;
   localparam int QUEUE_DEPTH         = 2;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_NOP    = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   // decoded operation, one-hot
   typedef enum logic [3:0] {
      OP_CLEAR  = 4'b0001,
      OP_APPEND = 4'b0010,
      OP_SEARCH = 4'b0100,
      OP_NOP    = 4'b1000
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0] value;
   } item_type;

endpackage

`default_nettype wire

[design/stbs_front.sv]
`default_nettype none

module stbs_front (
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_command,
   input  logic signed [stbs_pkg::VALUE_W-1:0] req_value,
   output logic                                 push_valid,
   input  logic                                 push_full,
   output stbs_pkg::item_type                   push_item
);

   always_comb begin
      push_item.value = req_value;
      unique case (stbs_pkg::command_type'(req_command))
         stbs_pkg::CMD_CLEAR:  push_item.op = stbs_pkg::OP_CLEAR;
         stbs_pkg::CMD_APPEND: push_item.op = stbs_pkg::OP_APPEND;
         stbs_pkg::CMD_SEARCH: push_item.op = stbs_pkg::OP_SEARCH;
         stbs_pkg::CMD_NOP:    push_item.op = stbs_pkg::OP_NOP;
         default:              push_item.op = stbs_pkg::OP_NOP;
      endcase
   end

   assign push_valid = req_valid;
   assign req_stall  = push_full;

endmodule

`default_nettype wire

[design/stbs_queue.sv]
`default_nettype none

module stbs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  stbs_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output stbs_pkg::item_type pop_item
);

   localparam int Depth = stbs_pkg::QUEUE_DEPTH;
   localparam int PW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int NW    = $clog2(Depth + 1);

   stbs_pkg::item_type entries_ff [Depth];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]      fill_ff, fill_in;
   logic               do_push, do_pop;

   assign full      = (fill_ff == NW'(Depth));
   assign pop_valid = (fill_ff != '0);
   assign pop_item  = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[design/stbs_back.sv]
`default_nettype none

module stbs_back #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  stbs_pkg::item_type            q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [stbs_pkg::INDEX_W-1:0] rsp_index
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = stbs_pkg::INDEX_W;
   localparam int VW = stbs_pkg::VALUE_W;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_PROBE = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   // search window is low .. hi-1
   logic [CW-1:0]        low_ff, low_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [AW-1:0]        mid_ff, mid_in;
   logic signed [VW-1:0] key_ff, key_in;
   logic signed [VW-1:0] rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic signed [VW-1:0] table_mem [TABLE_DEPTH];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [IW-1:0]        rsp_index_ff, rsp_index_in;
   logic                 res_load;
   stbs_pkg::status_type res_status;
   logic [IW-1:0]        res_index;

   logic                 out_free, probe_hit, probe_gt, next_empty;
   logic [CW-1:0]        mid_ext, nlow, nhi, nspan, nmid, start_mid;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign probe_hit = (rd_data_ff == key_ff);
   assign probe_gt  = (rd_data_ff > key_ff);
   assign mid_ext   = CW'(mid_ff);
   assign nlow      = probe_gt ? low_ff : mid_ext + 1'b1;
   assign nhi       = probe_gt ? mid_ext : hi_ff;
   assign next_empty = (nlow >= nhi);
   assign nspan     = nhi - nlow - 1'b1;
   assign nmid      = nlow + (nspan >> 1);
   assign start_mid = (count_ff - 1'b1) >> 1;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      low_in     = low_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      key_in     = key_ff;
      rd_addr    = mid_ff;
      wr_en      = 1'b0;
      q_pop      = 1'b0;
      res_load   = 1'b0;
      res_status = stbs_pkg::STATUS_DONE;
      res_index  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            q_pop = q_valid && out_free;
            if (q_pop) begin
               unique case (q_item.op)
                  stbs_pkg::OP_CLEAR: begin
                     count_in = '0;
                     res_load = 1'b1;
                  end
                  stbs_pkg::OP_APPEND: begin
                     res_load = 1'b1;
                     if (count_ff == CW'(TABLE_DEPTH)) begin
                        res_status = stbs_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  stbs_pkg::OP_SEARCH: begin
                     key_in = q_item.value;
                     if (count_ff == '0) begin
                        res_load   = 1'b1;
                        res_status = stbs_pkg::STATUS_NOT_FOUND;
                     end else begin
                        low_in   = '0;
                        hi_in    = count_ff;
                        mid_in   = start_mid[AW-1:0];
                        rd_addr  = start_mid[AW-1:0];
                        state_in = ST_PROBE;
                     end
                  end
                  default: begin
                     res_load = 1'b1;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            // rd_data_ff holds the entry at mid_ff; a finished search waits
            // here for the output register, rereading the same entry
            priority if (probe_hit) begin
               if (out_free) begin
                  res_load   = 1'b1;
                  res_status = stbs_pkg::STATUS_FOUND;
                  res_index  = IW'(mid_ff);
                  state_in   = ST_IDLE;
               end
            end else if (next_empty) begin
               if (out_free) begin
                  res_load   = 1'b1;
                  res_status = stbs_pkg::STATUS_NOT_FOUND;
                  state_in   = ST_IDLE;
               end
            end else begin
               low_in  = nlow;
               hi_in   = nhi;
               mid_in  = nmid[AW-1:0];
               rd_addr = nmid[AW-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in  = res_load || (rsp_valid_ff && rsp_stall);
      rsp_status_in = res_load ? res_status : rsp_status_ff;
      rsp_index_in  = res_load ? res_index : rsp_index_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff        <= low_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[count_ff[AW-1:0]] <= q_item.value;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_index  = rsp_index_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_window_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE |-> low_ff < hi_ff && hi_ff <= count_ff)
      else $error("search window empty or past the loaded entries");

   a_mid_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE |-> mid_ext >= low_ff && mid_ext < hi_ff)
      else $error("probe outside search window");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == ST_PROBE || rsp_valid_ff)
      else $error("popped word left neither a search nor a result");
`endif

endmodule

`default_nettype wire

[design/sorted_table_binary_search_top.sv]
`default_nettype none

// channel  dir  handshake             payload
// req      in   req_valid/req_stall   req_command[1:0], req_value[31:0] (signed)
// rsp      out  rsp_valid/rsp_stall   rsp_status[1:0], rsp_index[7:0]
//
// A word goes through a two-entry queue, whose entries and fill count are
// registered, and is popped into the executor when it is free. Clear,
// append and the unused command load the registered response as they are
// popped. A search probes the table through its registered read port, one
// probe per cycle until a finished search waits on a stalled result.
// Reset empties the table count; table contents are not cleared. A stalled
// result holds the executor; the queue keeps accepting until it is full.

module sorted_table_binary_search_top #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_command,
   input  logic signed [stbs_pkg::VALUE_W-1:0] req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [stbs_pkg::INDEX_W-1:0]        rsp_index
);

   logic               push_valid, push_full;
   stbs_pkg::item_type push_item;
   logic               q_valid, q_pop;
   stbs_pkg::item_type q_item;

   stbs_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_value   (req_value),
      .push_valid  (push_valid),
      .push_full   (push_full),
      .push_item   (push_item)
   );

   stbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (push_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (q_item)
   );

   stbs_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_status (rsp_status),
      .rsp_index  (rsp_index)
   );

endmodule

`default_nettype wire
